>>> design/stb_pkg.sv
// Sepia tone blend: shared widths, fixed-point constants and payload types.
// Used by the channel interfaces and by the top level; depends on nothing.
package stb_pkg;

  localparam int ChW        = 8;
  localparam int CoefW      = 12;
  localparam int FracBits   = 12;
  localparam int ProdW      = ChW + CoefW;
  localparam int SumW       = ProdW + 1;
  localparam int DiffW      = SumW + 1;
  localparam int KW         = 7;
  localparam int PrdKW      = DiffW + KW;
  localparam int BaseW      = 27;
  localparam int TW         = PrdKW + 1;
  localparam int UW         = 16;
  localparam int RecipW     = 17;
  localparam int RecipShift = 23;
  localparam int MulW       = UW + RecipW;
  localparam int QW         = MulW - RecipShift;
  localparam int NumStages  = 6;

  typedef logic [ChW-1:0]   chan_t;
  typedef chan_t [2:0]      rgb_t;
  typedef logic [CoefW-1:0] coef_t;
  typedef logic [KW-1:0]    pct_t;

  localparam pct_t PercentFull = 7'd100;

  // Q0.12 sepia matrix, rows red, green, blue
  localparam coef_t SepiaCoef [3][3] = '{
    '{12'd1610, 12'd3150, 12'd774},
    '{12'd1430, 12'd2810, 12'd688},
    '{12'd1114, 12'd2187, 12'd537}
  };

  localparam logic [BaseW-1:0]  BlendDiv  = 27'd409600;
  localparam logic [BaseW-1:0]  BlendHalf = 27'd204800;
  // ceil(2^23 / 100): exact floor division for any 16-bit dividend
  localparam logic [RecipW-1:0] Recip100  = 17'd83887;
  localparam chan_t             ChanMax   = 8'd255;

endpackage

>>> design/stb_in_if.sv
// Sepia tone blend: input pixel channel, valid/ready with RGBA payload.
// Depends on stb_pkg.
interface stb_in_if;
  logic            valid;
  logic            ready;
  stb_pkg::chan_t  red_in;
  stb_pkg::chan_t  green_in;
  stb_pkg::chan_t  blue_in;
  stb_pkg::chan_t  alpha_in;

  modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

>>> design/stb_out_if.sv
// Sepia tone blend: result pixel channel, valid/ready with RGBA payload.
// Depends on stb_pkg.
interface stb_out_if;
  logic            valid;
  logic            ready;
  stb_pkg::chan_t  red_out;
  stb_pkg::chan_t  green_out;
  stb_pkg::chan_t  blue_out;
  stb_pkg::chan_t  alpha_out;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

>>> design/sepia_tone_blend_top.sv
// Sepia tone blend top level: six-stage pipeline, sepia matrix then percent blend.
// Depends on stb_pkg, stb_in_if and stb_out_if.
//
// Takes one RGBA pixel per clock while the output does not stall and returns
// it with red, green and blue pushed through the sepia matrix and blended
// with the original by the intensity register (0 to 100 percent, values
// above 100 act as 100); alpha is copied. Each stage carries its own valid
// bit and loads whenever it is empty or the stage after it moves, so bubbles
// close up during an output stall and in_pix.ready only drops once all six
// stages hold items. Write cfg_wdata with cfg_we only while no item is in
// flight; it resets to 100.
module sepia_tone_blend_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  stb_pkg::pct_t        cfg_wdata,
  stb_in_if.sink               in_pix,
  stb_out_if.source            out_pix
);
  import stb_pkg::*;

  pct_t                         intensity_r;
  logic [NumStages-1:0]         v_r;
  logic [NumStages-1:0]         en;

  logic [2:0][2:0][ProdW-1:0]   prod0_r;
  rgb_t                         ch0_r, ch1_r;
  chan_t                        a0_r, a1_r, a2_r, a3_r, a4_r, a5_r;
  logic signed [DiffW-1:0]      d1_r [3];
  logic signed [PrdKW-1:0]      p2_r [3];
  logic [2:0][BaseW-1:0]        cb2_r;
  logic [2:0][UW-1:0]           u3_r;
  logic [2:0]                   neg3_r, big3_r, neg4_r, big4_r;
  logic [2:0][QW-1:0]           q4_r;
  rgb_t                         rgb5_r;

  pct_t                         k_eff;
  logic [SumW-1:0]              s_sum [3];
  logic signed [TW-1:0]         t_sum [3];
  logic [MulW-1:0]              m_prod [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intensity_r <= PercentFull;
    end else if (cfg_we) begin
      intensity_r <= cfg_wdata;
    end
  end

  always_comb begin
    en[NumStages-1] = !v_r[NumStages-1] || out_pix.ready;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_pix.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_pix.valid;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  assign k_eff = (intensity_r > PercentFull) ? PercentFull : intensity_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_sum[i] = SumW'(prod0_r[i][0]) + SumW'(prod0_r[i][1]) + SumW'(prod0_r[i][2]);
      t_sum[i] = TW'(p2_r[i]) + TW'($signed({1'b0, cb2_r[i]}));
      m_prod[i] = MulW'(u3_r[i]) * MulW'(Recip100);
    end
  end

  // stage 0: matrix products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ch0_r <= {in_pix.blue_in, in_pix.green_in, in_pix.red_in};
      a0_r  <= in_pix.alpha_in;
      for (int i = 0; i < 3; i++) begin
        prod0_r[i][0] <= ProdW'(SepiaCoef[i][0]) * ProdW'(in_pix.red_in);
        prod0_r[i][1] <= ProdW'(SepiaCoef[i][1]) * ProdW'(in_pix.green_in);
        prod0_r[i][2] <= ProdW'(SepiaCoef[i][2]) * ProdW'(in_pix.blue_in);
      end
    end
  end

  // stage 1: sepia sum minus original, both Q.12
  always_ff @(posedge clk) begin
    if (en[1]) begin
      ch1_r <= ch0_r;
      a1_r  <= a0_r;
      for (int i = 0; i < 3; i++) begin
        d1_r[i] <= $signed({1'b0, s_sum[i]}) -
                   $signed({2'b00, ch0_r[i], {FracBits{1'b0}}});
      end
    end
  end

  // stage 2: scale difference by intensity, build rounded base
  always_ff @(posedge clk) begin
    if (en[2]) begin
      a2_r <= a1_r;
      for (int i = 0; i < 3; i++) begin
        p2_r[i]  <= PrdKW'(d1_r[i]) * PrdKW'($signed({1'b0, k_eff}));
        cb2_r[i] <= BaseW'(ch1_r[i]) * BlendDiv + BlendHalf;
      end
    end
  end

  // stage 3: full blend sum, drop the Q.12 fraction
  always_ff @(posedge clk) begin
    if (en[3]) begin
      a3_r <= a2_r;
      for (int i = 0; i < 3; i++) begin
        u3_r[i]   <= t_sum[i][FracBits +: UW];
        neg3_r[i] <= t_sum[i][TW-1];
        big3_r[i] <= |t_sum[i][TW-2:FracBits+UW];
      end
    end
  end

  // stage 4: divide by one hundred through the reciprocal
  always_ff @(posedge clk) begin
    if (en[4]) begin
      a4_r   <= a3_r;
      neg4_r <= neg3_r;
      big4_r <= big3_r;
      for (int i = 0; i < 3; i++) begin
        q4_r[i] <= m_prod[i][MulW-1:RecipShift];
      end
    end
  end

  // stage 5: saturate and hold for the sink
  always_ff @(posedge clk) begin
    if (en[5]) begin
      a5_r <= a4_r;
      for (int i = 0; i < 3; i++) begin
        if (neg4_r[i]) begin
          rgb5_r[i] <= '0;
        end else if (big4_r[i] || (q4_r[i] > QW'(ChanMax))) begin
          rgb5_r[i] <= ChanMax;
        end else begin
          rgb5_r[i] <= q4_r[i][ChW-1:0];
        end
      end
    end
  end

  assign out_pix.valid     = v_r[NumStages-1];
  assign out_pix.red_out   = rgb5_r[0];
  assign out_pix.green_out = rgb5_r[1];
  assign out_pix.blue_out  = rgb5_r[2];
  assign out_pix.alpha_out = a5_r;

`ifndef SYNTHESIS
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_pix.ready |-> (&v_r))
    else $error("input blocked while a stage is empty");

  a_blend_non_negative: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[3] |-> (neg3_r == 3'b000))
    else $error("blend sum negative with clamped intensity");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> (v_r == '0))
    else $error("pipeline holds items after reset");
`endif

endmodule

>>> dv/stb_sepia_chk.sv
`timescale 1ns / 100ps
// Sepia blend checker: watches the pixel channels and the intensity port,
// predicts every result pixel and compares it field by field with the block.
// Depends on stb_pkg, stb_in_if and stb_out_if.
module stb_sepia_chk (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  stb_pkg::pct_t  cfg_wdata,
  stb_in_if              in_mon,
  stb_out_if             out_mon,
  output int             n_fail,
  output int             n_due
);
  import stb_pkg::*;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
  } pix_t;

  localparam longint Q12One   = 4096;
  localparam longint PctScale = 100;
  localparam longint BlendDen = Q12One * PctScale;
  localparam longint BlendRnd = BlendDen / 2;
  localparam longint Mat [3][3] = '{
    '{1610, 3150, 774},
    '{1430, 2810, 688},
    '{1114, 2187, 537}
  };

  pct_t blend_pct;
  pix_t sepia_due [$];
  int   n_res;

  function automatic chan_t blend_chan(longint c, longint s, longint k);
    longint t;
    t = c * BlendDen + (s - c * Q12One) * k + BlendRnd;
    if (t < 0) return '0;
    t = t / BlendDen;
    if (t > 255) return 8'd255;
    return t[7:0];
  endfunction

  function automatic pix_t sepia_blend_px(pix_t px, pct_t pct);
    longint c [3];
    longint k;
    longint s;
    chan_t  res [3];
    pix_t   o;
    c[0] = longint'(px.red);
    c[1] = longint'(px.green);
    c[2] = longint'(px.blue);
    k = (pct > PercentFull) ? PctScale : longint'(pct);
    for (int i = 0; i < 3; i++) begin
      s = Mat[i][0] * c[0] + Mat[i][1] * c[1] + Mat[i][2] * c[2];
      res[i] = blend_chan(c[i], s, k);
    end
    o.red   = res[0];
    o.green = res[1];
    o.blue  = res[2];
    o.alpha = px.alpha;
    return o;
  endfunction

  task automatic report(input string what, input int got, input int want);
    if (n_fail < 40) $display("%0t ns  %s: got %0d, want %0d", $time, what, got, want);
    n_fail++;
  endtask

  always @(posedge clk) begin : watch
    pix_t got;
    pix_t want;
    pix_t seen;
    if (!rst_n) begin
      blend_pct = PercentFull;
      sepia_due.delete();
    end else begin
      if (cfg_we) blend_pct = cfg_wdata;
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.red_out, out_mon.green_out, out_mon.blue_out, out_mon.alpha_out};
        if (sepia_due.size() == 0) begin
          report("result item with nothing due", n_res, -1);
        end else begin
          want = sepia_due.pop_front();
          if (got.red != want.red) report("red_out", int'(got.red), int'(want.red));
          if (got.green != want.green) begin
            report("green_out", int'(got.green), int'(want.green));
          end
          if (got.blue != want.blue) report("blue_out", int'(got.blue), int'(want.blue));
          if (got.alpha != want.alpha) begin
            report("alpha_out", int'(got.alpha), int'(want.alpha));
          end
        end
        n_res++;
      end
      if (in_mon.valid && in_mon.ready) begin
        seen = '{in_mon.red_in, in_mon.green_in, in_mon.blue_in, in_mon.alpha_in};
        sepia_due.push_back(sepia_blend_px(seen, blend_pct));
      end
    end
    n_due = sepia_due.size();
  end

endmodule

>>> dv/sepia_tone_blend_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the sepia tone blend: clock, reset, pixel and intensity
// stimulus with random gaps and stalls; verdict from stb_sepia_chk.
// Depends on stb_pkg, stb_in_if, stb_out_if, stb_sepia_chk and the block.
module sepia_tone_blend_top_tb;
  import stb_pkg::*;

  localparam int PhaseItems = 125;
  localparam int PhasePct [10] = '{0, 127, 1, 99, 101, 50, -1, -1, 64, 100};

  logic clk;
  logic rst_n;
  logic cfg_we;
  pct_t cfg_wdata;
  int   n_fail;
  int   n_due;
  int   n_sent;
  int   n_settings;
  bit   calm;

  stb_in_if  in_pix ();
  stb_out_if out_pix ();

  sepia_tone_blend_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_pix    (in_pix),
    .out_pix   (out_pix)
  );

  stb_sepia_chk chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_mon    (in_pix),
    .out_mon   (out_pix),
    .n_fail    (n_fail),
    .n_due     (n_due)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_pix(input chan_t r, input chan_t g, input chan_t b, input chan_t a);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_pix.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_pix.valid    <= 1'b1;
    in_pix.red_in   <= r;
    in_pix.green_in <= g;
    in_pix.blue_in  <= b;
    in_pix.alpha_in <= a;
    do @(posedge clk); while (!in_pix.ready);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic hold_until_empty();
    in_pix.valid <= 1'b0;
    do @(negedge clk); while (n_due != 0);
  endtask

  task automatic set_intensity(input pct_t v);
    hold_until_empty();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic send_random_pix();
    chan_t c [3];
    int    mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      if (mode == 0) c[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else c[i] = chan_t'($urandom_range(0, 255));
    end
    if (mode == 1) begin
      c[1] = c[0];
      c[2] = c[0];
    end
    send_pix(c[0], c[1], c[2], chan_t'($urandom_range(0, 255)));
  endtask

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    in_pix.valid    <= 1'b0;
    in_pix.red_in   <= '0;
    in_pix.green_in <= '0;
    in_pix.blue_in  <= '0;
    in_pix.alpha_in <= '0;
    n_sent     = 0;
    n_settings = 1;
    calm       = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed pixels at the reset intensity
    send_pix(8'h00, 8'h00, 8'h00, 8'h00);
    send_pix(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pix(8'hFF, 8'h00, 8'h00, 8'h80);
    send_pix(8'h00, 8'hFF, 8'h00, 8'h7F);
    send_pix(8'h00, 8'h00, 8'hFF, 8'h01);
    send_pix(8'hFF, 8'hFF, 8'h00, 8'hFE);
    send_pix(8'h80, 8'h80, 8'h80, 8'h00);
    send_pix(8'h01, 8'h01, 8'h01, 8'hFF);
    send_pix(8'hAA, 8'h55, 8'hAA, 8'h55);
    send_pix(8'h55, 8'hAA, 8'h55, 8'hAA);
    send_pix(8'h40, 8'h20, 8'h10, 8'hC3);
    send_pix(8'h00, 8'h00, 8'h01, 8'h3C);
    set_intensity(pct_t'(0));
    send_pix(8'hFF, 8'h00, 8'hFF, 8'h11);
    send_pix(8'h7F, 8'h80, 8'h01, 8'hEE);
    set_intensity(pct_t'(127));
    send_pix(8'hFF, 8'hFF, 8'hFF, 8'h00);
    send_pix(8'h01, 8'h02, 8'h03, 8'hFF);
    set_intensity(pct_t'(101));
    send_pix(8'hC8, 8'h64, 8'h32, 8'h99);
    set_intensity(pct_t'(1));
    send_pix(8'h00, 8'hFF, 8'h00, 8'h66);
    send_pix(8'hFF, 8'h00, 8'h00, 8'h33);

    for (int p = 0; p < 10; p++) begin
      if (PhasePct[p] < 0) set_intensity(pct_t'($urandom_range(0, 127)));
      else set_intensity(pct_t'(PhasePct[p]));
      for (int i = 0; i < PhaseItems; i++) begin
        if (i % 32 == 0) calm = ($urandom_range(0, 3) == 0);
        if (p == 4 && i == 60) hold_until_empty();
        send_random_pix();
      end
    end

    calm = 1'b0;
    hold_until_empty();
    repeat (NumStages * 4) @(negedge clk);
    $display("Sent %0d pixels across %0d intensity settings, incl. 0, 100 and above 100,",
             n_sent, n_settings);
    $display("with random input gaps and output stalls.");
    if (n_fail == 0 && n_due == 0) begin
      $display("sepia_tone_blend_top_tb OK");
    end else begin
      $display("sepia_tone_blend_top_tb NOT OK");
    end
    $finish;
  end

  initial begin
    int burst;
    int stall;
    out_pix.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      out_pix.ready <= 1'b1;
      repeat (burst) @(negedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_pix.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  initial begin
    #3000000;
    $display("sepia_tone_blend_top_tb NOT OK");
    $finish;
  end

endmodule
